/* rtl/core/ps2md_pkg.sv */
// PS/2 mouse packet decoder: shared types and constants.
// No dependencies; imported by ps2_mouse_packet_decoder_top.
`timescale 1ns / 1ps

package ps2md_pkg;

    localparam int BYTE_W    = 8;
    localparam int DX_W      = 9;
    localparam int DY_W      = 10;
    localparam int WHEEL_W   = 9;
    localparam int BUTTONS_W = 5;
    localparam int COUNT_W   = 2;
    localparam int STORE_D   = 3;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Mouse identity codes
    localparam byte_t ID_WHEEL     = 8'd3;
    localparam byte_t ID_FIVE_BTN  = 8'd4;

    // Byte 0 bit positions
    localparam int B0_SYNC_BIT  = 3;
    localparam int B0_XSIGN_BIT = 4;
    localparam int B0_YSIGN_BIT = 5;
    localparam byte_t B0_OVF_MASK = 8'hc0;

    // Byte counts at which a packet completes
    localparam count_t LAST_IDX_SHORT = 2'd2;
    localparam count_t LAST_IDX_LONG  = 2'd3;

endpackage

/* rtl/core/ps2_mouse_packet_decoder_top.sv */
// PS/2 mouse packet decoder, top level and only module.
// Depends on ps2md_pkg (widths, identity codes, byte 0 bit positions).
`timescale 1ns / 1ps

// Accepts one raw PS/2 mouse byte per transfer on the data_byte channel and
// assembles 3-byte packets (or 4-byte IntelliMouse packets when device_id is
// 3 or 4). While no packet is in progress, a byte with bit 3 clear is dropped
// to regain sync. A completed packet with either overflow bit of byte 0 set
// is dropped; any other packet yields one transfer on the result channel with
// delta_x, delta_y (negated, positive is down), wheel (negated) and buttons.
// Throughput is one byte per clock cycle while in_stall is low; the last byte
// of a packet passes through the input register, and its result is then
// registered in the result register until it is taken. in_stall
// rises only when the result register holds an untaken result and the input
// register holds a byte. device_id is written through the cfg port (always
// ready) and must only change while the block holds no byte in flight.
module ps2_mouse_packet_decoder_top
    import ps2md_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BYTE_W-1:0]    cfg_data,
    // input byte channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [DX_W-1:0]    delta_x,
    output logic signed [DY_W-1:0]    delta_y,
    output logic signed [WHEEL_W-1:0] wheel,
    output logic [BUTTONS_W-1:0] buttons
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    byte_t  device_id_reg;
    count_t byte_count_reg, byte_count_next;
    byte_t  store_reg [STORE_D];

    logic   s1_valid_reg;
    byte_t  s1_byte_reg;

    logic                       out_valid_reg;
    logic signed [DX_W-1:0]     delta_x_reg, delta_x_next;
    logic signed [DY_W-1:0]     delta_y_reg, delta_y_next;
    logic signed [WHEEL_W-1:0]  wheel_reg, wheel_next;
    logic [BUTTONS_W-1:0]       buttons_reg, buttons_next;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_free;   // result register can take a new result this cycle
    logic s1_fire;    // byte in the input register is processed this cycle
    logic in_fire;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Packet assembly and decode of the byte held in the input register
    // ------------------------------------------------------------------
    logic   long_pkt;
    logic   sync_drop;
    logic   complete;
    logic   store_en;
    logic   emit;
    count_t last_idx;
    byte_t  b0, b1, b2, b3;
    logic signed [DY_W-1:0]    y_raw;
    logic signed [WHEEL_W-1:0] w_raw;

    always_comb
    begin
        long_pkt  = (device_id_reg == ID_WHEEL) || (device_id_reg == ID_FIVE_BTN);
        last_idx  = long_pkt ? LAST_IDX_LONG : LAST_IDX_SHORT;
        sync_drop = (byte_count_reg == '0) && !s1_byte_reg[B0_SYNC_BIT];
        // a count beyond the last index (id changed mid-packet) also completes
        complete  = !sync_drop && (byte_count_reg >= last_idx);
        store_en  = !sync_drop && !complete;

        byte_count_next = byte_count_reg;
        if (complete)
        begin
            byte_count_next = '0;
        end
        else if (store_en)
        begin
            byte_count_next = byte_count_reg + count_t'(1);
        end

        b0 = store_reg[0];
        b1 = store_reg[1];
        if (long_pkt)
        begin
            b2 = store_reg[2];
            b3 = s1_byte_reg;
        end
        else
        begin
            b2 = s1_byte_reg;
            b3 = '0;
        end

        emit = complete && ((b0 & B0_OVF_MASK) == '0);

        delta_x_next = {b0[B0_XSIGN_BIT], b1};
        y_raw        = {b0[B0_YSIGN_BIT], b0[B0_YSIGN_BIT], b2};
        delta_y_next = -y_raw;

        case (device_id_reg)
            ID_WHEEL:    w_raw = {b3[7], b3};
            ID_FIVE_BTN: w_raw = {{(WHEEL_W-4){b3[3]}}, b3[3:0]};
            default:     w_raw = '0;
        endcase
        wheel_next = -w_raw;

        buttons_next = {2'b00, b0[2:0]};
        if (device_id_reg == ID_FIVE_BTN)
        begin
            buttons_next[4:3] = b3[5:4];
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg  <= '0;
            byte_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                device_id_reg <= cfg_data;
            end
            // hold the input register while stalled, advance otherwise
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                byte_count_reg <= byte_count_next;
            end
            // drop a taken result unless a new one replaces it
            if (out_free)
            begin
                out_valid_reg <= s1_fire && emit;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= data_byte;
        end
        if (s1_fire && store_en)
        begin
            store_reg[byte_count_reg] <= s1_byte_reg;
        end
        if (s1_fire && emit)
        begin
            delta_x_reg <= delta_x_next;
            delta_y_reg <= delta_y_next;
            wheel_reg   <= wheel_next;
            buttons_reg <= buttons_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign delta_x   = delta_x_reg;
    assign delta_y   = delta_y_reg;
    assign wheel     = wheel_reg;
    assign buttons   = buttons_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_emit_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit) |=> (byte_count_reg == '0))
        else $error("byte count not cleared after a packet result");

    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("input register lost a byte while stalled");

    a_result_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(s1_valid_reg))
        else $error("result appeared without a processed byte");

endmodule
